// ===== src/aessb_pkg.sv =====
// Shared types, constants and GF(2^8) helper functions for the AES S-box core.
`timescale 1ns / 1ps

package aessb_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned APB_AW    = 3;

	// Register map (byte addresses, one 32-bit word per register)
	localparam logic [APB_AW-1:0] REG_INVERSE_MODE = 3'h0;

	localparam logic [8:0]        GF_POLY     = 9'h11B;
	localparam logic [7:0]        AFF_FWD_C   = 8'h63;
	localparam logic [7:0]        AFF_INV_C   = 8'h05;

	typedef struct packed {
		logic             inv_mode;
		logic [BYTE_W-1:0] data;
	} aessb_item_t;

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] gf_reduce(input logic [14:0] p);
		logic [14:0] r;
		r = p;
		for (int i = 14; i >= 8; i--) begin
			if (r[i]) begin
				r = r ^ (15'(GF_POLY) << (i - 8));
			end
		end
		return r[7:0];
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [14:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ (15'(a) << i);
			end
		end
		return gf_reduce(p);
	endfunction

	// Squaring is linear: spread the bits, then reduce
	function automatic logic [7:0] gf_sq(input logic [7:0] a);
		logic [14:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			p[2*i] = a[i];
		end
		return gf_reduce(p);
	endfunction

	function automatic logic [7:0] affine_fwd(input logic [7:0] b);
		return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AFF_FWD_C;
	endfunction

	function automatic logic [7:0] affine_inv(input logic [7:0] s);
		return rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ AFF_INV_C;
	endfunction

endpackage

// ===== src/aessb_cfg_regs.sv =====
// APB register block holding the forward/inverse mode select.
`timescale 1ns / 1ps

module aessb_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aessb_pkg::APB_AW-1:0] paddr,
	input  logic [aessb_pkg::APB_DW-1:0] pwdata,
	output logic [aessb_pkg::APB_DW-1:0] prdata,
	output logic                         pready,
	output logic                         inv_mode
);
	import aessb_pkg::*;

	logic inv_mode_q;
	logic hit;

	// Decode on the word address only
	assign hit = (paddr[APB_AW-1:2] == REG_INVERSE_MODE[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && hit) begin
			inv_mode_q <= pwdata[0];
		end
	end

	assign prdata   = hit ? {{(APB_DW-1){1'b0}}, inv_mode_q} : '0;
	assign pready   = 1'b1;
	assign inv_mode = inv_mode_q;

endmodule

// ===== src/aessb_inv_pipe.sv =====
// Four-stage GF(2^8) inversion pipeline computing a^254 by an addition chain.
`timescale 1ns / 1ps

module aessb_inv_pipe (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_stall,
	input  aessb_pkg::aessb_item_t up_item,
	output logic                   dn_valid,
	input  logic                   dn_stall,
	output aessb_pkg::aessb_item_t dn_item
);
	import aessb_pkg::*;

	logic       valid_s2, valid_s3, valid_s4, valid_s5;
	logic       en_s2, en_s3, en_s4, en_s5;
	logic       mode_s2, mode_s3, mode_s4, mode_s5;
	logic [7:0] a_s2, a_s3, a_s4, a_s5;
	logic [7:0] a3_s2, a3_s3;
	logic [7:0] a15_s3;
	logic [7:0] a252_s4;
	logic [7:0] inv_s5;

	// A stage loads when empty or when the next one moves
	assign en_s5 = !valid_s5 || !dn_stall;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign up_stall = !en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s2) valid_s2 <= up_valid;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// a^3, a^15, a^252 = (a^15)^16 * a^12, a^254 = a^252 * a^2
	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2 <= up_item.inv_mode;
			a_s2    <= up_item.data;
			a3_s2   <= gf_mul(gf_sq(up_item.data), up_item.data);
		end
		if (en_s3) begin
			mode_s3 <= mode_s2;
			a_s3    <= a_s2;
			a3_s3   <= a3_s2;
			a15_s3  <= gf_mul(gf_sq(gf_sq(a3_s2)), a3_s2);
		end
		if (en_s4) begin
			mode_s4 <= mode_s3;
			a_s4    <= a_s3;
			a252_s4 <= gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(a15_s3)))), gf_sq(gf_sq(a3_s3)));
		end
		if (en_s5) begin
			mode_s5 <= mode_s4;
			a_s5    <= a_s4;
			inv_s5  <= gf_mul(a252_s4, gf_sq(a_s4));
		end
	end

	assign dn_valid         = valid_s5;
	assign dn_item.inv_mode = mode_s5;
	assign dn_item.data     = inv_s5;

	ap_inverse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && (a_s5 != 8'h00) |-> gf_mul(inv_s5, a_s5) == 8'h01)
		else $error("field inverse does not multiply back to one");

	ap_zero_maps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && (a_s5 == 8'h00) |-> inv_s5 == 8'h00)
		else $error("zero operand did not map to zero");

	ap_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !en_s4 |=> valid_s4 && $stable(a252_s4))
		else $error("stage 4 lost its item while blocked");

endmodule

// ===== src/aes_sbox_forward_inverse_core.sv =====
// Pipeline: out_valid rises once an accepted in_byte has passed six register stages (input affine,
// 4 inversion stages, output affine).
// Throughput: one item per cycle; stalls back-pressure through every stage with no loss.
// The GF(2^8) inverse is a four-multiplier addition chain, one multiply per stage.
// Reset: arst_n clears all valid bits and sets inverse_mode to 0 (forward S-box).
`timescale 1ns / 1ps

module aes_sbox_forward_inverse_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aessb_pkg::APB_AW-1:0] paddr,
	input  logic [aessb_pkg::APB_DW-1:0] pwdata,
	output logic [aessb_pkg::APB_DW-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [aessb_pkg::BYTE_W-1:0] in_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [aessb_pkg::BYTE_W-1:0] out_byte
);
	import aessb_pkg::*;

	logic        inv_mode;
	logic        valid_s1, en_s1;
	aessb_item_t item_s1;
	logic        pipe_stall;
	logic        pipe_valid;
	aessb_item_t pipe_item;
	logic        pipe_dn_stall;
	logic        valid_s6, en_s6;
	logic [7:0]  byte_s6;

	aessb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.inv_mode (inv_mode)
	);

	assign en_s6         = !valid_s6 || !out_stall;
	assign pipe_dn_stall = !en_s6;
	assign en_s1         = !valid_s1 || !pipe_stall;
	assign in_stall      = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s6) valid_s6 <= pipe_valid;
		end
	end

	// Inverse mode undoes the affine map before inversion; forward applies it after
	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1.inv_mode <= inv_mode;
			item_s1.data     <= inv_mode ? affine_inv(in_byte) : in_byte;
		end
		if (en_s6) begin
			byte_s6 <= pipe_item.inv_mode ? pipe_item.data : affine_fwd(pipe_item.data);
		end
	end

	aessb_inv_pipe u_inv (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_stall (pipe_stall),
		.up_item  (item_s1),
		.dn_valid (pipe_valid),
		.dn_stall (pipe_dn_stall),
		.dn_item  (pipe_item)
	);

	assign out_valid = valid_s6;
	assign out_byte  = byte_s6;

	ap_empty_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled while first stage is empty");

	ap_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	ap_drain_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !out_stall && !pipe_valid |=> !valid_s6)
		else $error("output item repeated after delivery");

endmodule
